// ===== hw/rtl/ole_pkg.sv =====
`default_nettype none

package ole_pkg;

    // List geometry
    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);

    // Operation codes on the op port
    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_PREPEND = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_DUMP    = 2'd3
    } op_t;

    // Status codes on the status port
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    // What a cell loads at the next edge
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_KEY,
        CELL_FROM_LEFT,
        CELL_ROTATE,
        CELL_CLOSE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      valid;   // cell holds a live entry
        logic      tail;    // cell holds the tail entry
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ole_cell.sv =====
`default_nettype none

module ole_cell (
    input  wire logic                clk,
    input  wire ole_pkg::cell_ctrl_t ctrl,
    input  wire logic signed [31:0]  key,
    input  wire logic signed [31:0]  left_data,
    input  wire logic signed [31:0]  right_data,
    input  wire logic signed [31:0]  head_data,
    input  wire logic                seen_in,
    output logic signed [31:0]       data,
    output logic                     seen_out
);
    import ole_pkg::*;

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               match;

    // Compare against the key and pass the first-match flag down the chain
    always_comb
    begin
        match    = ctrl.valid && (entry_reg == key);
        seen_out = seen_in | match;
    end

    // Select the next entry
    always_comb
    begin
        case (ctrl.cmd)
            CELL_HOLD:      entry_next = entry_reg;
            CELL_LOAD_KEY:  entry_next = key;
            CELL_FROM_LEFT: entry_next = left_data;
            CELL_ROTATE:    entry_next = ctrl.tail ? head_data : right_data;
            CELL_CLOSE:     entry_next = seen_out ? right_data : entry_reg;
            default:        entry_next = entry_reg;
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_engine.sv =====
`default_nettype none

// Ordered list of up to LIST_DEPTH signed 32-bit values.
// Input channel: op and value are taken at a rising edge with start high and
// busy low. op selects append at tail, prepend at head, remove first match,
// or dump front to back.
// Result channel: each result is on status, entry_value, position,
// entry_count and last for exactly one cycle while strobe is high; last
// marks the final result of an item. The receiver cannot stall, so no
// result is ever held back.
// Flow: append and prepend give their result in the cycle after the
// transfer and busy stays low, so one item per cycle. A remove holds busy
// in its compare state, where the row of cells compares and closes up; the
// result is registered from that state. A dump rotates the cell row once
// per result and holds busy until it gives its last entry.
// Removes and dumps on an empty list, and inserts into a full list, answer
// without leaving idle, in the cycle after the transfer.
// Reset: the list is empty after reset; cell contents are not cleared and
// are never read before they are written.
module ordered_list_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] value,
    output logic                    busy,
    output logic                    strobe,
    output logic [1:0]              status,
    output logic signed [31:0]      entry_value,
    output logic [5:0]              position,
    output logic [6:0]              entry_count,
    output logic                    last
);
    import ole_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_DUMP
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [31:0] key_reg, key_next;

    logic               strobe_reg, strobe_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] entry_value_reg, entry_value_next;
    logic [5:0]         position_reg, position_next;
    logic [6:0]         entry_count_reg, entry_count_next;
    logic               last_reg, last_next;

    logic               accept;
    logic               full;
    logic               found;
    logic               dump_last;
    logic signed [31:0] key;
    cell_cmd_t          row_cmd;

    cell_ctrl_t         ctrl [LIST_DEPTH];
    logic signed [31:0] data [LIST_DEPTH];
    logic               seen [LIST_DEPTH+1];

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign full      = (count_reg == CNT_W'(LIST_DEPTH));
    assign found     = seen[LIST_DEPTH];
    assign dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign key       = (state_reg == S_IDLE) ? value : key_reg;
    assign seen[0]   = 1'b0;

    // Pick the row-wide cell command
    always_comb
    begin
        row_cmd = CELL_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !full && op == OP_APPEND)
                    row_cmd = CELL_LOAD_KEY;
                else if (accept && !full && op == OP_PREPEND)
                    row_cmd = CELL_FROM_LEFT;
            end
            S_MATCH: row_cmd = CELL_CLOSE;
            S_DUMP:  row_cmd = CELL_ROTATE;
            default: row_cmd = CELL_HOLD;
        endcase
    end

    // Build the row of cells
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        // Narrow the row command to this cell
        always_comb
        begin
            ctrl[i].valid = (CNT_W'(i) < count_reg);
            ctrl[i].tail  = (CNT_W'(i + 1) == count_reg);
            ctrl[i].cmd   = row_cmd;
            if (row_cmd == CELL_LOAD_KEY && CNT_W'(i) != count_reg)
                ctrl[i].cmd = CELL_HOLD;
            if (row_cmd == CELL_FROM_LEFT && i == 0)
                ctrl[i].cmd = CELL_LOAD_KEY;
        end

        ole_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .key        (key),
            .left_data  (data[(i == 0) ? 0 : i - 1]),
            .right_data (data[(i == LIST_DEPTH - 1) ? i : i + 1]),
            .head_data  (data[0]),
            .seen_in    (seen[i]),
            .data       (data[i]),
            .seen_out   (seen[i + 1])
        );
    end

    // Sequence operations and form results
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        key_next         = key_reg;
        strobe_next      = 1'b0;
        status_next      = STATUS_OK;
        entry_value_next = '0;
        position_next    = '0;
        entry_count_next = 7'(count_reg);
        last_next        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_APPEND, OP_PREPEND:
                        begin
                            strobe_next = 1'b1;
                            if (full)
                                status_next = STATUS_FULL;
                            else
                            begin
                                count_next       = count_reg + CNT_W'(1);
                                entry_count_next = 7'(count_reg + CNT_W'(1));
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                key_next   = value;
                                state_next = S_MATCH;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_MATCH:
            begin
                strobe_next = 1'b1;
                state_next  = S_IDLE;
                if (found)
                begin
                    count_next       = count_reg - CNT_W'(1);
                    entry_count_next = 7'(count_reg - CNT_W'(1));
                end
                else
                    status_next = STATUS_NOT_FOUND;
            end
            S_DUMP:
            begin
                strobe_next      = 1'b1;
                entry_value_next = data[0];
                position_next    = 6'(idx_reg);
                last_next        = dump_last;
                idx_next         = idx_reg + IDX_W'(1);
                if (dump_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state, fill count, dump index and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        status_reg      <= status_next;
        entry_value_reg <= entry_value_next;
        position_reg    <= position_next;
        entry_count_reg <= entry_count_next;
        last_reg        <= last_next;
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign entry_value = entry_value_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;
    assign last        = last_reg;

    // The fill count never passes the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("fill count beyond list depth");

    // A compare cycle always ends the item with one final result
    a_match_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MATCH |=> strobe && last && state_reg == S_IDLE)
        else $error("remove gave no final result");

    // A result that is not final belongs to a dump still in progress
    a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> state_reg == S_DUMP)
        else $error("non-final result outside a dump");

    // A dump walks only over live entries
    a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> CNT_W'(idx_reg) < count_reg)
        else $error("dump index past the tail");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import ole_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    // One result as it appears on the result ports
    typedef struct packed {
        status_t            status;
        logic signed [31:0] entry_value;
        logic [5:0]         position;
        logic [6:0]         entry_count;
        logic               last;
    } list_result_t;

    // Mirror of the list contents plus the queue of results still owed
    class list_scoreboard;
        logic signed [31:0] held [LIST_DEPTH];
        int unsigned        fill;
        list_result_t       awaited [$];
        int unsigned        errors;

        // Update the mirror for one accepted transfer and queue its results
        function void note_request(op_t code, logic signed [31:0] operand);
            list_result_t r;
            int unsigned  idx;
            r = '{status: STATUS_OK, entry_value: '0, position: '0,
                  entry_count: '0, last: 1'b1};
            case (code)
                OP_APPEND, OP_PREPEND:
                begin
                    if (fill >= LIST_DEPTH)
                    begin
                        r.status = STATUS_FULL;
                    end
                    else if (code == OP_APPEND)
                    begin
                        held[fill] = operand;
                        fill++;
                    end
                    else
                    begin
                        for (int i = fill; i > 0; i--)
                            held[i] = held[i - 1];
                        held[0] = operand;
                        fill++;
                    end
                    r.entry_count = fill[6:0];
                    awaited.push_back(r);
                end
                OP_REMOVE:
                begin
                    if (fill == 0)
                    begin
                        r.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        idx = fill;
                        for (int i = fill - 1; i >= 0; i--)
                            if (held[i] == operand)
                                idx = i;
                        if (idx == fill)
                        begin
                            r.status = STATUS_NOT_FOUND;
                        end
                        else
                        begin
                            // close up behind the removed entry
                            for (int i = idx; i + 1 < fill; i++)
                                held[i] = held[i + 1];
                            fill--;
                        end
                    end
                    r.entry_count = fill[6:0];
                    awaited.push_back(r);
                end
                default:
                begin
                    if (fill == 0)
                    begin
                        r.status = STATUS_EMPTY;
                        awaited.push_back(r);
                    end
                    else
                    begin
                        for (int i = 0; i < fill; i++)
                        begin
                            r.entry_value = held[i];
                            r.position    = i[5:0];
                            r.entry_count = fill[6:0];
                            r.last        = (i + 1 == fill);
                            awaited.push_back(r);
                        end
                    end
                end
            endcase
        endfunction

        function void report_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one strobed result against the oldest owed result
        function void check_result(list_result_t act);
            list_result_t exp_r;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, act);
                errors++;
                return;
            end
            exp_r = awaited.pop_front();
            report_field("status", 32'(exp_r.status), 32'(act.status));
            report_field("entry_value", exp_r.entry_value, act.entry_value);
            report_field("position", 32'(exp_r.position), 32'(act.position));
            report_field("entry_count", 32'(exp_r.entry_count), 32'(act.entry_count));
            report_field("last", 32'(exp_r.last), 32'(act.last));
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [1:0]         op;
    logic signed [31:0] value;
    logic               busy;
    logic               strobe;
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic [5:0]         position;
    logic [6:0]         entry_count;
    logic               last;

    list_scoreboard sb;
    int unsigned    sender_idle_pct;
    int unsigned    quiet_cycles;
    logic signed [31:0] value_pool [6] = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fff_ffff,
                                            32'sh8000_0000, 32'sd42};

    ordered_list_engine DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .value       (value),
        .busy        (busy),
        .strobe      (strobe),
        .status      (status),
        .entry_value (entry_value),
        .position    (position),
        .entry_count (entry_count),
        .last        (last)
    );

    // Free-running clock
    always #5 clk = ~clk;

    // Record transfers, check results, and guard against a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(op_t'(op), value);
            if (strobe)
                sb.check_result('{status: status_t'(status), entry_value: entry_value,
                                  position: position, entry_count: entry_count,
                                  last: last});
            if ((start && !busy) || strobe)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Present one operation, idling first at random, and hold it until taken
    task automatic send_item(input op_t code, input logic signed [31:0] operand);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        op    <= code;
        value <= operand;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Alternate fill-heavy and drain-heavy stretches to drive the list toward full and toward empty
    task automatic send_random_items(input int count);
        int unsigned        pick;
        bit                 filling;
        op_t                code;
        logic signed [31:0] operand;
        for (int n = 0; n < count; n++)
        begin
            pick    = $urandom_range(99);
            filling = ((n / 20) % 2) == 0;
            if (pick < 10)
                code = OP_DUMP;
            else if ((pick < 90) == filling)
                code = $urandom_range(1) ? OP_PREPEND : OP_APPEND;
            else
                code = OP_REMOVE;
            operand = ($urandom_range(99) < 65) ? value_pool[$urandom_range(5)] : $urandom;
            send_item(code, operand);
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        op              = OP_APPEND;
        value           = '0;
        quiet_cycles    = 0;
        sender_idle_pct = 6;
        sb              = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty list: remove and dump both report empty
        send_item(OP_REMOVE, 32'sd7);
        send_item(OP_DUMP, 32'sd0);
        // Extremes at both ends
        send_item(OP_APPEND, 32'sh8000_0000);
        send_item(OP_PREPEND, 32'sh7fff_ffff);
        send_item(OP_APPEND, 32'sd0);
        send_item(OP_PREPEND, -32'sd1);
        send_item(OP_DUMP, 32'sh5a5a_5a5a);
        // Absent value, then removal at tail and head
        send_item(OP_REMOVE, 32'sd12345);
        send_item(OP_REMOVE, 32'sd0);
        send_item(OP_REMOVE, -32'sd1);
        // Fill to capacity with duplicates near the head
        for (int i = 0; i < LIST_DEPTH - 2; i++)
        begin
            if (i % 2 == 0)
                send_item(OP_PREPEND, 32'sd3);
            else
                send_item(OP_APPEND, $urandom);
        end
        // Inserts into a full list are rejected
        send_item(OP_APPEND, 32'sd9);
        send_item(OP_PREPEND, 32'sd9);
        send_item(OP_DUMP, 32'sd0);
        send_item(OP_REMOVE, 32'sd3);

        send_random_items(28);
        sender_idle_pct = 86;
        send_random_items(27);
        sender_idle_pct = 0;
        send_random_items(27);

        // Drop start, drain owed results, then let the pipe settle
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0t: %0d mismatches, %0d results never seen", $time,
                     sb.errors, sb.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
